/* design/npc_pkg.sv */
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search block.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COLOR_W             = 8;
    localparam int ENTRY_IDX_W         = 8;
    localparam int DIST_W              = 18;
    localparam int MAX_DIST            = 195075;
    // Only indexes below this can ever be written through the 8-bit index field.
    localparam int WRITABLE_ENTRIES    = 256;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [COLOR_W-1:0]     red;
        logic [COLOR_W-1:0]     green;
        logic [COLOR_W-1:0]     blue;
    } in_word_t;

    typedef struct packed {
        logic [ENTRY_IDX_W-1:0] nearest_index;
        logic [DIST_W-1:0]      min_distance;
    } out_word_t;

endpackage

`default_nettype wire

/* design/nearest_palette_color_search.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// RGB palette store with a nearest-color search by squared distance.
// ----------------------------------------------------------------------------
// A write word stores one palette entry and gives no result.
// A query word scans the palette from index 0 upward through one read port and
// one shared distance unit, one entry per cycle; once the read and distance
// stages have drained after the scan, its result word is loaded into the
// output register (later only if the previous result has not been taken).
// Ties go to the lowest index. The input is not ready while a scan runs, but
// writes are taken while a result word waits at the output. The palette reads
// as black after reset through per-entry valid bits, so no clearing pass is
// needed. Entries at index 256 and above always read as black, and the
// reported index is the low 8 bits of the winning index.
`default_nettype none

module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire npc_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output npc_pkg::out_word_t      m_data
);
    import npc_pkg::*;

    localparam int IDX_W   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int STORE   = (PALETTE_ENTRIES < WRITABLE_ENTRIES) ?
                             PALETTE_ENTRIES : WRITABLE_ENTRIES;
    localparam int STORE_W = (STORE > 1) ? $clog2(STORE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [STORE-1:0]       valid_reg;
    logic [3*COLOR_W-1:0]   mem [STORE];

    logic [COLOR_W-1:0]     q_red_reg, q_green_reg, q_blue_reg;
    logic [IDX_W-1:0]       scan_idx_reg;

    // Stage 1: registered memory read.
    logic                   p1_vld_reg;
    logic [IDX_W-1:0]       p1_idx_reg;
    logic [3*COLOR_W-1:0]   rd_data_reg;
    logic                   rd_ok_reg;
    // Stage 2: registered distance.
    logic                   p2_vld_reg;
    logic [IDX_W-1:0]       p2_idx_reg;
    logic [DIST_W-1:0]      dist_reg;

    logic [IDX_W-1:0]       best_idx_reg;
    logic [DIST_W-1:0]      low_dist_reg;

    logic                   m_valid_reg;
    out_word_t              m_data_reg;

    logic                   s_fire;
    logic                   wr_en;
    logic                   res_load;
    logic [STORE_W-1:0]     rd_addr;
    logic                   rd_in_range;
    logic [3*COLOR_W-1:0]   entry;
    logic [DIST_W-1:0]      scan_dist;
    logic [31:0]            best_idx_ext;

    function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (2*COLOR_W)'(d) * (2*COLOR_W)'(d);
    endfunction

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign wr_en       = s_fire && (s_data.op == OP_WRITE) &&
                         (32'(s_data.entry_index) < PALETTE_ENTRIES);
    assign res_load    = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign rd_addr     = scan_idx_reg[STORE_W-1:0];
    assign rd_in_range = (32'(scan_idx_reg) < STORE);

    // Entries never written, or beyond the writable range, read as black.
    assign entry     = rd_ok_reg ? rd_data_reg : '0;
    assign scan_dist = DIST_W'(sq_diff(entry[3*COLOR_W-1:2*COLOR_W], q_red_reg))
                     + DIST_W'(sq_diff(entry[2*COLOR_W-1:COLOR_W], q_green_reg))
                     + DIST_W'(sq_diff(entry[COLOR_W-1:0], q_blue_reg));

    assign best_idx_ext = 32'(best_idx_reg);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s_data.entry_index[STORE_W-1:0]] <= {s_data.red, s_data.green, s_data.blue};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[s_data.entry_index[STORE_W-1:0]] <= 1'b1;
            end

            p1_vld_reg  <= (state_reg == ST_SCAN);
            p1_idx_reg  <= scan_idx_reg;
            rd_ok_reg   <= rd_in_range && valid_reg[rd_addr];
            p2_vld_reg  <= p1_vld_reg;
            p2_idx_reg  <= p1_idx_reg;
            dist_reg    <= scan_dist;

            // Strictly smaller only, so the lowest index wins a tie.
            if (s_fire && (s_data.op == OP_QUERY)) begin
                best_idx_reg <= '0;
                low_dist_reg <= '1;
            end else if (p2_vld_reg && (dist_reg < low_dist_reg)) begin
                low_dist_reg <= dist_reg;
                best_idx_reg <= p2_idx_reg;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_data.op == OP_QUERY)) begin
                        q_red_reg     <= s_data.red;
                        q_green_reg   <= s_data.green;
                        q_blue_reg    <= s_data.blue;
                        scan_idx_reg  <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (scan_idx_reg == LAST_IDX) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!p1_vld_reg && !p2_vld_reg) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (res_load) begin
                        m_data_reg.nearest_index   <= best_idx_ext[ENTRY_IDX_W-1:0];
                        m_data_reg.min_distance    <= low_dist_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A query holds off the input for the rest of its scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.op == OP_QUERY)) |=> !s_ready)
        else $error("input ready right after a query was accepted");

    // A fresh result word only comes out of the finish step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result word appeared outside the finish step");

    // The distance pipeline only carries entries while a scan is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        p2_vld_reg |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("distance stage active outside a scan");

    // Any delivered distance is within the squared RGB range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.min_distance) <= MAX_DIST))
        else $error("result distance out of range");

endmodule

`default_nettype wire

/* dv/palette_search_checker.sv */
// ----------------------------------------------------------------------------
// palette_search_checker
// Watches both channels of the nearest palette color search block. It keeps
// its own copy of the palette, works out the answer to every accepted query
// word, and compares each accepted result word with the oldest answer owed.
// ----------------------------------------------------------------------------
module palette_search_checker #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  npc_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  npc_pkg::out_word_t m_data,
    output int                 mismatches,
    output int                 results_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import npc_pkg::*;

    logic [3*COLOR_W-1:0] palette_copy [PALETTE_ENTRIES];
    out_word_t            owed_results [$];
    out_word_t            oldest_owed;

    function automatic int channel_gap_sq(input logic [COLOR_W-1:0] a,
                                          input logic [COLOR_W-1:0] b);
        int diff;
        diff = int'(a) - int'(b);
        return diff * diff;
    endfunction

    // Strict less-than over an upward scan keeps the lowest index on a tie.
    // Stopping at an exact match would give the same answer, so the scan
    // simply runs to the end.
    function automatic out_word_t nearest_entry(input logic [COLOR_W-1:0] r,
                                                input logic [COLOR_W-1:0] g,
                                                input logic [COLOR_W-1:0] b);
        out_word_t          answer;
        int                 low_dist;
        int                 best_idx;
        int                 gap_sum;
        logic [COLOR_W-1:0] pr;
        logic [COLOR_W-1:0] pg;
        logic [COLOR_W-1:0] pb;
        low_dist = 0;
        best_idx = 0;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            {pr, pg, pb} = palette_copy[i];
            gap_sum = channel_gap_sq(pr, r) + channel_gap_sq(pg, g) + channel_gap_sq(pb, b);
            if (i == 0 || gap_sum < low_dist) begin
                low_dist = gap_sum;
                best_idx = i;
            end
        end
        answer.nearest_index = best_idx[ENTRY_IDX_W-1:0];
        answer.min_distance  = low_dist[DIST_W-1:0];
        return answer;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                palette_copy[i] = '0;
            end
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result word idx=%0d dist=%0d with nothing owed",
                                              m_data.nearest_index, m_data.min_distance));
                end else begin
                    oldest_owed = owed_results.pop_front();
                    if (m_data.nearest_index !== oldest_owed.nearest_index) begin
                        report_mismatch($sformatf("nearest_index got %0d want %0d",
                                                  m_data.nearest_index,
                                                  oldest_owed.nearest_index));
                    end
                    if (m_data.min_distance !== oldest_owed.min_distance) begin
                        report_mismatch($sformatf("min_distance got %0d want %0d",
                                                  m_data.min_distance,
                                                  oldest_owed.min_distance));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.op == OP_WRITE) begin
                    if (int'(s_data.entry_index) < PALETTE_ENTRIES) begin
                        palette_copy[s_data.entry_index] = {s_data.red, s_data.green,
                                                            s_data.blue};
                    end
                end else begin
                    owed_results.push_back(nearest_entry(s_data.red, s_data.green,
                                                         s_data.blue));
                end
            end
        end
        results_owed = owed_results.size();
    end
endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the nearest palette color search block: a directed opening
// on the extremes and tie cases, then random palette writes and queries with
// random idling on both channels, a long output stall, and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import npc_pkg::*;

    localparam int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int LONG_HOLD       = 2500;
    localparam int SETTLE_CYCLES   = 300;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    int          mismatches;
    int          results_owed;
    int unsigned cycle_count = 0;

    bit          tx_idle      = 1'b1;
    bit          rx_idle      = 1'b1;
    bit          rx_hold_req  = 1'b0;
    logic [23:0] used_colors [$];

    nearest_palette_color_search #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    palette_search_checker #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) watcher (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic in_word_t color_word(input logic op, input logic [7:0] idx,
                                            input logic [23:0] rgb);
        in_word_t w;
        w.op          = op;
        w.entry_index = idx;
        {w.red, w.green, w.blue} = rgb;
        return w;
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Most queries hit or land next to a color already stored, so exact
    // matches and close ties are common; writes sometimes reuse a color.
    function automatic in_word_t pick_random_word(input int query_pct);
        in_word_t    w;
        int unsigned roll;
        logic [23:0] base;
        w.op          = OP_QUERY;
        w.entry_index = 8'($urandom_range(0, 255));
        w.red         = 8'($urandom_range(0, 255));
        w.green       = 8'($urandom_range(0, 255));
        w.blue        = 8'($urandom_range(0, 255));
        base          = {w.red, w.green, w.blue};
        if (used_colors.size() > 0) begin
            base = used_colors[$urandom_range(0, used_colors.size() - 1)];
        end
        roll = $urandom_range(0, 99);
        if (roll >= query_pct) begin
            w.op = OP_WRITE;
            if (roll % 7 == 0) begin
                {w.red, w.green, w.blue} = base;
            end
        end else if (roll % 3 == 0) begin
            {w.red, w.green, w.blue} = base;
        end else if (roll % 3 == 1) begin
            w.red   = nudge(base[23:16]);
            w.green = nudge(base[15:8]);
            w.blue  = nudge(base[7:0]);
        end
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, 19)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.op == OP_WRITE) begin
            used_colors.push_back({w.red, w.green, w.blue});
        end
        @(negedge aclk);
    endtask

    task automatic send_random(input int count, input int query_pct);
        repeat (count) send_word(pick_random_word(query_pct));
    endtask

    task automatic wait_results_drained();
        while (results_owed != 0) @(negedge aclk);
    endtask

    // Result side: random stall per word, plus one long hold on request.
    initial begin
        int wait_n;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            wait_n = rx_idle ? int'($urandom_range(0, 19)) : 0;
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Queries on the all-black palette, including the largest distance.
        send_word(color_word(OP_QUERY, 8'h00, 24'h000000));
        send_word(color_word(OP_QUERY, 8'hFF, 24'hFFFFFF));
        // Top index, then midpoint that sits nearer to white than to black.
        send_word(color_word(OP_WRITE, 8'hFF, 24'hFFFFFF));
        send_word(color_word(OP_QUERY, 8'h00, 24'hFFFFFF));
        send_word(color_word(OP_QUERY, 8'h55, 24'h808080));
        send_word(color_word(OP_WRITE, 8'h00, 24'hFF0000));
        send_word(color_word(OP_WRITE, 8'h01, 24'h00FF00));
        send_word(color_word(OP_WRITE, 8'h02, 24'h0000FF));
        send_word(color_word(OP_WRITE, 8'hAA, 24'hAA55AA));
        send_word(color_word(OP_WRITE, 8'h55, 24'h55AA55));
        send_word(color_word(OP_QUERY, 8'hFF, 24'hAA55AA));
        send_word(color_word(OP_QUERY, 8'hAA, 24'h55AA55));
        // Same color at two indexes: exact and off-by-one ties go low.
        send_word(color_word(OP_WRITE, 8'd20, 24'h0A141E));
        send_word(color_word(OP_WRITE, 8'd200, 24'h0A141E));
        send_word(color_word(OP_QUERY, 8'h00, 24'h0A141E));
        send_word(color_word(OP_QUERY, 8'h00, 24'h0B141E));
        // Two different colors at equal distance from the query.
        send_word(color_word(OP_WRITE, 8'd30, 24'h282828));
        send_word(color_word(OP_WRITE, 8'd31, 24'h2A2828));
        send_word(color_word(OP_QUERY, 8'h7F, 24'h292828));
        // Black is still held by the untouched entries above index 2.
        send_word(color_word(OP_QUERY, 8'h80, 24'h000000));
        send_word(color_word(OP_QUERY, 8'h01, 24'hFF0000));
        send_word(color_word(OP_QUERY, 8'h02, 24'h0000FE));

        send_random(250, 60);

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(150, 60);

        // Output held off while queries keep coming, so the input backs up.
        rx_hold_req = 1'b1;
        send_random(60, 80);
        s_valid <= 1'b0;
        wait_results_drained();

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_random(170, 60);
        s_valid <= 1'b0;

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
